/* sv/mtfrq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Move-to-front ring queue package
// Shared widths, defaults, operation and status codes.
// ----------------------------------------------------------------------------
package mtfrq_pkg;

    localparam int DATA_W              = 32;
    localparam int OP_W                = 3;
    localparam int ST_W                = 2;
    localparam int CNT_W               = 5;
    localparam int DEFAULT_MAX_ENTRIES = 16;

    localparam logic [CNT_W-1:0] DEFAULT_CAPACITY = 5'd10;

    typedef logic [OP_W-1:0] op_t;
    typedef logic [ST_W-1:0] status_t;

    localparam op_t OP_ENQUEUE    = 3'd0;
    localparam op_t OP_PUSH       = 3'd1;
    localparam op_t OP_REMOVE     = 3'd2;
    localparam op_t OP_MOVE_FRONT = 3'd3;
    localparam op_t OP_MOVE_REAR  = 3'd4;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_FULL      = 2'd1;
    localparam status_t ST_EMPTY     = 2'd2;
    localparam status_t ST_NOT_FOUND = 2'd3;

endpackage
`default_nettype wire

/* sv/mtfrq_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mtfrq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] store_mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

/* sv/move_to_front_ring_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Move-to-front ring queue
// Ordered store of 32-bit values in a ring buffer RAM, with enqueue, push,
// remove, move-to-front and move-to-rear operations and one result per item.
// ----------------------------------------------------------------------------
// One item is taken at a time. Enqueue, push, unknown operations and any item
// refused as full or empty go from acceptance straight to the finish state;
// remove passes through a capture state for the read data first. A move scans
// the RAM from the front, one entry per cycle, then shifts the entries between
// the match and the chosen end, one entry per cycle through the single read and
// single write port, and finally writes the moved value at the front or rear; a
// value that is not found ends the scan after the last entry with nothing
// written. The result register frees the input side while a result waits to be
// taken.
// The entry RAM needs no clearing after reset.
module move_to_front_ring_queue
    import mtfrq_pkg::*;
#(
    parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [OP_W-1:0]          operation,
    input  wire logic signed [DATA_W-1:0] item_value,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [ST_W-1:0]               status,
    output logic signed [DATA_W-1:0]      removed_value,
    output logic [CNT_W-1:0]              entry_count,
    input  wire logic                     cfg_wr_en,
    input  wire logic [CNT_W-1:0]         cfg_wr_data
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int SUM_W = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CAPTURE = 3'd1;
    localparam logic [2:0] S_SEARCH  = 3'd2;
    localparam logic [2:0] S_SHIFT   = 3'd3;
    localparam logic [2:0] S_FIXUP   = 3'd4;
    localparam logic [2:0] S_FINISH  = 3'd5;

    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                  input logic [CNT_W-1:0] pos);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(pos);
        if (sum >= SUM_W'(MAX_ENTRIES))
        begin
            sum = sum - SUM_W'(MAX_ENTRIES);
        end
        return sum[IDX_W-1:0];
    endfunction

    logic [2:0]              state_reg, state_next;
    logic [CNT_W-1:0]        capacity_reg;
    logic [CNT_W-1:0]        held_reg, held_next;
    logic [IDX_W-1:0]        head_reg, head_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    wpend_reg, wpend_next;
    logic                    cmp_valid_reg, cmp_valid_next;

    op_t                     op_reg, op_next;
    logic [DATA_W-1:0]       val_reg, val_next;
    logic [CNT_W-1:0]        pos_reg, pos_next;
    logic [CNT_W-1:0]        left_reg, left_next;
    logic [CNT_W-1:0]        wpos_reg, wpos_next;
    logic [CNT_W-1:0]        cmp_pos_reg, cmp_pos_next;
    status_t                 res_status_reg, res_status_next;
    logic [DATA_W-1:0]       res_removed_reg, res_removed_next;
    status_t                 status_reg, status_next;
    logic [DATA_W-1:0]       removed_reg, removed_next;
    logic [CNT_W-1:0]        count_reg, count_next;

    logic [CNT_W-1:0]        cap_base;
    logic [CNT_W-1:0]        cap_used;
    logic                    to_front;

    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [DATA_W-1:0]       wr_data;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic [DATA_W-1:0]       rd_data;

    mtfrq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        cap_base = (capacity_reg == '0) ? DEFAULT_CAPACITY : capacity_reg;
        if (int'(cap_base) > MAX_ENTRIES)
        begin
            cap_used = CNT_W'(MAX_ENTRIES);
        end
        else
        begin
            cap_used = cap_base;
        end
    end

    assign to_front = (op_reg == OP_MOVE_FRONT);
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        held_next        = held_reg;
        head_next        = head_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        wpend_next       = 1'b0;
        cmp_valid_next   = 1'b0;
        op_next          = op_reg;
        val_next         = val_reg;
        pos_next         = pos_reg;
        left_next        = left_reg;
        wpos_next        = wpos_reg;
        cmp_pos_next     = cmp_pos_reg;
        res_status_next  = res_status_reg;
        res_removed_next = res_removed_reg;
        status_next      = status_reg;
        removed_next     = removed_reg;
        count_next       = count_reg;

        wr_en   = 1'b0;
        wr_addr = slot_of(head_reg, wpos_reg);
        wr_data = rd_data;
        rd_en   = 1'b0;
        rd_addr = slot_of(head_reg, pos_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next          = operation;
                    val_next         = $unsigned(item_value);
                    res_status_next  = ST_OK;
                    res_removed_next = '0;
                    pos_next         = '0;
                    state_next       = S_FINISH;
                    unique case (operation) inside
                        OP_ENQUEUE, OP_PUSH:
                        begin
                            if (held_reg >= cap_used)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else if (operation == OP_ENQUEUE)
                            begin
                                wr_en     = 1'b1;
                                wr_addr   = slot_of(head_reg, held_reg);
                                wr_data   = $unsigned(item_value);
                                held_next = held_reg + CNT_W'(1);
                            end
                            else
                            begin
                                head_next = (head_reg == '0) ? IDX_W'(MAX_ENTRIES - 1)
                                                             : head_reg - IDX_W'(1);
                                wr_en     = 1'b1;
                                wr_addr   = head_next;
                                wr_data   = $unsigned(item_value);
                                held_next = held_reg + CNT_W'(1);
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (held_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = head_reg;
                                head_next  = (head_reg == IDX_W'(MAX_ENTRIES - 1))
                                             ? '0 : head_reg + IDX_W'(1);
                                held_next  = held_reg - CNT_W'(1);
                                state_next = S_CAPTURE;
                            end
                        end
                        OP_MOVE_FRONT, OP_MOVE_REAR:
                        begin
                            if (held_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_SEARCH;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_CAPTURE:
            begin
                res_removed_next = rd_data;
                state_next       = S_FINISH;
            end

            S_SEARCH:
            begin
                if (cmp_valid_reg && (rd_data == val_reg))
                begin
                    if (to_front)
                    begin
                        pos_next  = cmp_pos_reg - CNT_W'(1);
                        left_next = cmp_pos_reg;
                    end
                    else
                    begin
                        pos_next  = cmp_pos_reg + CNT_W'(1);
                        left_next = held_reg - CNT_W'(1) - cmp_pos_reg;
                    end
                    state_next = S_SHIFT;
                end
                else if (cmp_valid_reg && (cmp_pos_reg == held_reg - CNT_W'(1)))
                begin
                    res_status_next = ST_NOT_FOUND;
                    state_next      = S_FINISH;
                end
                else
                begin
                    rd_en          = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_pos_next   = pos_reg;
                    pos_next       = pos_reg + CNT_W'(1);
                end
            end

            S_SHIFT:
            begin
                wr_en = wpend_reg;
                if (left_reg != '0)
                begin
                    rd_en      = 1'b1;
                    wpend_next = 1'b1;
                    left_next  = left_reg - CNT_W'(1);
                    if (to_front)
                    begin
                        wpos_next = pos_reg + CNT_W'(1);
                        pos_next  = pos_reg - CNT_W'(1);
                    end
                    else
                    begin
                        wpos_next = pos_reg - CNT_W'(1);
                        pos_next  = pos_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    state_next = S_FIXUP;
                end
            end

            S_FIXUP:
            begin
                wr_en      = 1'b1;
                wr_data    = val_reg;
                wr_addr    = slot_of(head_reg, to_front ? '0 : held_reg - CNT_W'(1));
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    removed_next   = res_removed_reg;
                    count_next     = held_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            capacity_reg  <= DEFAULT_CAPACITY;
            held_reg      <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
            wpend_reg     <= 1'b0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
            wpend_reg     <= wpend_next;
            cmp_valid_reg <= cmp_valid_next;
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        val_reg         <= val_next;
        pos_reg         <= pos_next;
        left_reg        <= left_next;
        wpos_reg        <= wpos_next;
        cmp_pos_reg     <= cmp_pos_next;
        res_status_reg  <= res_status_next;
        res_removed_reg <= res_removed_next;
        status_reg      <= status_next;
        removed_reg     <= removed_next;
        count_reg       <= count_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign removed_value = $signed(removed_reg);
    assign entry_count   = count_reg;

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(held_reg) <= MAX_ENTRIES)
        else $error("held count above ring size");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(head_reg) < MAX_ENTRIES)
        else $error("head index outside ring");

    a_ring_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid && in_ready) |=> ($stable(held_reg) && $stable(head_reg)))
        else $error("ring pointers changed without an accepted item");

    a_search_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (held_reg != '0))
        else $error("search started on an empty queue");

    a_shift_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && wpend_reg && left_reg != '0) |-> (wr_addr != rd_addr))
        else $error("shift read and write hit the same entry");
`endif

endmodule
`default_nettype wire
